/* design/sorted_record_table_unit_assert.svh */
// Assertion macros for the sorted record table, empty in synthesis.
`ifndef SORTED_RECORD_TABLE_UNIT_ASSERT_SVH
`define SORTED_RECORD_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SRT_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define SRT_ASSERT(lbl, cond, msg)
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/srt_pkg.sv */
// Shared types and constants of the sorted record table.
package srt_pkg;
   localparam int SCORE_W    = 10;
   localparam int WEIGHT_W   = 11;
   localparam int OUT_ID_W   = 56;
   localparam int OUT_NAME_W = 64;
   localparam int PROD_W     = SCORE_W + WEIGHT_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam logic [SCORE_W-1:0] AVG_MAX = 10'd1000;

   localparam logic [WEIGHT_W-1:0] WEIGHT_FIRST_RST  = 11'd307;
   localparam logic [WEIGHT_W-1:0] WEIGHT_SECOND_RST = 11'd307;
   localparam logic [WEIGHT_W-1:0] WEIGHT_THIRD_RST  = 11'd410;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_EDIT   = 2'd1;
   localparam logic [1:0] OP_LIST   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   localparam logic [1:0] REG_WEIGHT_FIRST  = 2'd0;
   localparam logic [1:0] REG_WEIGHT_SECOND = 2'd1;
   localparam logic [1:0] REG_WEIGHT_THIRD  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_CALC1, S_CALC2, S_INS_BEGIN, S_FIND_RD, S_FIND_CHK,
      S_DROP_RD, S_DROP_WR, S_INS_RD, S_INS_CHK, S_INS_PUT,
      S_LIST_RD, S_LIST_OUT, S_RESP
   } state_type;
endpackage

/* design/srt_mem.sv */
// Record memory: one write port, one read port with registered read data.
module srt_mem #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wa,
   input  logic [WIDTH-1:0]         wd,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] ra,
   output logic [WIDTH-1:0]         rd
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   assign rd = rd_ff;
endmodule

/* design/srt_avg.sv */
// Two-stage weighted average: register products, then sum, shift and saturate.
module srt_avg
   import srt_pkg::*;
(
   input  logic                clock,
   input  logic [SCORE_W-1:0]  s1,
   input  logic [SCORE_W-1:0]  s2,
   input  logic [SCORE_W-1:0]  s3,
   input  logic [WEIGHT_W-1:0] w1,
   input  logic [WEIGHT_W-1:0] w2,
   input  logic [WEIGHT_W-1:0] w3,
   output logic [SCORE_W-1:0]  avg
);
   logic [PROD_W-1:0]  p1_ff, p2_ff, p3_ff;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-11:0]  shifted;
   logic [SCORE_W-1:0] avg_ff;

   assign sum     = SUM_W'(p1_ff) + SUM_W'(p2_ff) + SUM_W'(p3_ff);
   assign shifted = sum[SUM_W-1:10];

   always_ff @(posedge clock) begin
      p1_ff  <= PROD_W'(s1) * PROD_W'(w1);
      p2_ff  <= PROD_W'(s2) * PROD_W'(w2);
      p3_ff  <= PROD_W'(s3) * PROD_W'(w3);
      avg_ff <= (shifted > (SUM_W-10)'(AVG_MAX)) ? AVG_MAX : shifted[SCORE_W-1:0];
   end

   assign avg = avg_ff;
endmodule

/* design/sorted_record_table_unit.sv */
// Top level of the sorted record table: control sequencer around the record memory.
//
// Sorted record table. Up to DEPTH records (id, name, three scores, weighted
// average) are held in one synchronous memory in ascending order of the
// name's first byte. Requests are taken one at a time. Insert walks down from
// the top of the table, moving each entry whose first byte is equal or greater
// up one place, then writes the new record into the gap; edit scans from the
// bottom for the first whole-name match, closes the gap over it and then
// inserts the new record the same way. List reads the entries in order and
// emits one result transfer each. Every memory visit is a read issue, then
// compare and write back on the registered read data; the insert walk reads
// every entry it moves plus the one it stops at, if any. Accesses never touch
// the same entry in neighboring cycles, so no forwarding is needed. Weights
// are written through the csr_ port; the user must write them only while the
// table is idle, which the block itself does not enforce. Indexes beyond the
// third are dropped.
module sorted_record_table_unit
   import srt_pkg::*;
#(
   parameter int DEPTH      = 32,
   parameter int NAME_BYTES = 8,
   parameter int ID_BYTES   = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [OUT_NAME_W-1:0] req_match_name,
   input  logic [OUT_ID_W-1:0]   req_new_id,
   input  logic [OUT_NAME_W-1:0] req_new_name,
   input  logic [SCORE_W-1:0]    req_score_one,
   input  logic [SCORE_W-1:0]    req_score_two,
   input  logic [SCORE_W-1:0]    req_score_three,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [OUT_ID_W-1:0]   rsp_out_id,
   output logic [OUT_NAME_W-1:0] rsp_out_name,
   output logic [SCORE_W-1:0]    rsp_out_score_one,
   output logic [SCORE_W-1:0]    rsp_out_score_two,
   output logic [SCORE_W-1:0]    rsp_out_score_three,
   output logic [SCORE_W-1:0]    rsp_out_average,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [WEIGHT_W-1:0]   csr_data
);
`include "sorted_record_table_unit_assert.svh"

   localparam int NW    = 8 * NAME_BYTES;
   localparam int IDW   = 8 * ID_BYTES;
   localparam int REC_W = IDW + NW + 4 * SCORE_W;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   // field offsets inside a record word: {id, name, s1, s2, s3, avg}
   localparam int AVG_LO  = 0;
   localparam int S3_LO   = SCORE_W;
   localparam int S2_LO   = 2 * SCORE_W;
   localparam int S1_LO   = 3 * SCORE_W;
   localparam int NAME_LO = 4 * SCORE_W;
   localparam int ID_LO   = NAME_LO + NW;

   // configuration
   logic [WEIGHT_W-1:0] weight_first_ff, weight_second_ff, weight_third_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_first_ff  <= WEIGHT_FIRST_RST;
         weight_second_ff <= WEIGHT_SECOND_RST;
         weight_third_ff  <= WEIGHT_THIRD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WEIGHT_FIRST:  weight_first_ff  <= csr_data;
            REG_WEIGHT_SECOND: weight_second_ff <= csr_data;
            REG_WEIGHT_THIRD:  weight_third_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // control and request holding registers
   state_type           state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [1:0]          st_ff, st_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [NW-1:0]       match_ff, match_in;
   logic [IDW-1:0]      id_ff, id_in;
   logic [NW-1:0]       name_ff, name_in;
   logic [SCORE_W-1:0]  s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [SCORE_W-1:0]  avg;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [OUT_ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [OUT_NAME_W-1:0] rsp_name_ff, rsp_name_in;
   logic [SCORE_W-1:0]    rsp_s1_ff, rsp_s1_in, rsp_s2_ff, rsp_s2_in;
   logic [SCORE_W-1:0]    rsp_s3_ff, rsp_s3_in, rsp_avg_ff, rsp_avg_in;
   logic                  rsp_last_ff, rsp_last_in;

   // memory port
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_wa, mem_ra;
   logic [REC_W-1:0] mem_wd, mem_rd, new_rec, out_rec;

   logic out_free;
   logic list_last;
   logic list_done;
   logic full_resp;

   srt_avg u_avg (
      .clock (clock),
      .s1    (s1_ff),
      .s2    (s2_ff),
      .s3    (s3_ff),
      .w1    (weight_first_ff),
      .w2    (weight_second_ff),
      .w3    (weight_third_ff),
      .avg   (avg)
   );

   srt_mem #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .wa    (mem_wa),
      .wd    (mem_wd),
      .re    (mem_re),
      .ra    (mem_ra),
      .rd    (mem_rd)
   );

   assign new_rec   = {id_ff, name_ff, s1_ff, s2_ff, s3_ff, avg};
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign list_last = (CW'(idx_ff + 1'b1) == count_ff);
   assign list_done = (state_ff == S_LIST_OUT) && out_free && list_last;
   assign full_resp = (state_ff == S_RESP) && (st_ff == ST_FULL);
   assign req_ready = (state_ff == S_IDLE);
   // the record a status-ok result carries: the read entry when listing,
   // otherwise the one just placed
   assign out_rec   = (state_ff == S_LIST_OUT) ? mem_rd : new_rec;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      st_in         = st_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      match_in      = match_ff;
      id_in         = id_ff;
      name_in       = name_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      s3_in         = s3_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff[AW-1:0];
      mem_wd        = mem_rd;
      mem_re        = 1'b0;
      mem_ra        = idx_ff[AW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_name_in   = rsp_name_ff;
      rsp_s1_in     = rsp_s1_ff;
      rsp_s2_in     = rsp_s2_ff;
      rsp_s3_in     = rsp_s3_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               match_in = req_match_name[NW-1:0];
               id_in    = req_new_id[IDW-1:0];
               name_in  = req_new_name[NW-1:0];
               s1_in    = req_score_one;
               s2_in    = req_score_two;
               s3_in    = req_score_three;
               idx_in   = '0;
               case (req_operation)
                  OP_INSERT, OP_EDIT: state_in = S_CALC1;
                  OP_LIST: begin
                     if (count_ff == '0) begin
                        st_in    = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_LIST_RD;
                     end
                  end
                  default: ;   // unused code: drop the transfer
               endcase
            end
         end
         S_CALC1: state_in = S_CALC2;
         S_CALC2: begin
            if (op_ff == OP_INSERT) begin
               if (count_ff == CW'(DEPTH)) begin
                  st_in    = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  state_in = S_INS_BEGIN;
               end
            end else if (count_ff == '0) begin
               st_in    = ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               state_in = S_FIND_RD;
            end
         end
         S_FIND_RD: begin
            mem_re   = 1'b1;
            state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            idx_in = CW'(idx_ff + 1'b1);
            if (mem_rd[NAME_LO +: NW] == match_ff) begin
               if (list_last) begin
                  count_in = CW'(count_ff - 1'b1);
                  state_in = S_INS_BEGIN;
               end else begin
                  state_in = S_DROP_RD;
               end
            end else if (list_last) begin
               st_in    = ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               state_in = S_FIND_RD;
            end
         end
         S_DROP_RD: begin
            mem_re   = 1'b1;
            state_in = S_DROP_WR;
         end
         S_DROP_WR: begin
            // move the entry one place down over the removed one
            mem_we = 1'b1;
            mem_wa = AW'(idx_ff - 1'b1);
            idx_in = CW'(idx_ff + 1'b1);
            if (list_last) begin
               count_in = CW'(count_ff - 1'b1);
               state_in = S_INS_BEGIN;
            end else begin
               state_in = S_DROP_RD;
            end
         end
         S_INS_BEGIN: begin
            idx_in   = count_ff;
            state_in = (count_ff == '0) ? S_INS_PUT : S_INS_RD;
         end
         S_INS_RD: begin
            mem_re   = 1'b1;
            mem_ra   = AW'(idx_ff - 1'b1);
            state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (mem_rd[NAME_LO+NW-8 +: 8] >= name_ff[NW-1 -: 8]) begin
               // entry sorts at or after the new one: move it up
               mem_we   = 1'b1;
               idx_in   = CW'(idx_ff - 1'b1);
               state_in = (idx_ff == CW'(1)) ? S_INS_PUT : S_INS_RD;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            mem_we   = 1'b1;
            mem_wd   = new_rec;
            count_in = CW'(count_ff + 1'b1);
            st_in    = ST_OK;
            state_in = S_RESP;
         end
         S_LIST_RD: begin
            mem_re   = 1'b1;
            state_in = S_LIST_OUT;
         end
         S_LIST_OUT, S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (state_ff == S_LIST_OUT) ? ST_OK : st_ff;
               rsp_last_in   = (state_ff == S_RESP) || list_last;
               if ((state_ff == S_LIST_OUT) || (st_ff == ST_OK)) begin
                  rsp_id_in   = OUT_ID_W'(out_rec[ID_LO +: IDW]);
                  rsp_name_in = OUT_NAME_W'(out_rec[NAME_LO +: NW]);
                  rsp_s1_in   = out_rec[S1_LO +: SCORE_W];
                  rsp_s2_in   = out_rec[S2_LO +: SCORE_W];
                  rsp_s3_in   = out_rec[S3_LO +: SCORE_W];
                  rsp_avg_in  = out_rec[AVG_LO +: SCORE_W];
               end else begin
                  rsp_id_in   = '0;
                  rsp_name_in = '0;
                  rsp_s1_in   = '0;
                  rsp_s2_in   = '0;
                  rsp_s3_in   = '0;
                  rsp_avg_in  = '0;
               end
               if ((state_ff == S_RESP) || list_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = CW'(idx_ff + 1'b1);
                  state_in = S_LIST_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         op_ff        <= OP_INSERT;
         st_ff        <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         op_ff        <= op_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff      <= match_in;
      id_ff         <= id_in;
      name_ff       <= name_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      s3_ff         <= s3_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_s1_ff     <= rsp_s1_in;
      rsp_s2_ff     <= rsp_s2_in;
      rsp_s3_ff     <= rsp_s3_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_out_id          = rsp_id_ff;
   assign rsp_out_name        = rsp_name_ff;
   assign rsp_out_score_one   = rsp_s1_ff;
   assign rsp_out_score_two   = rsp_s2_ff;
   assign rsp_out_score_three = rsp_s3_ff;
   assign rsp_out_average     = rsp_avg_ff;
   assign rsp_last            = rsp_last_ff;

   `SRT_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "entry count above table depth")
   `SRT_ASSERT(a_put_room, (state_ff != S_INS_PUT) || (count_ff < CW'(DEPTH)), "put into full table")
   `SRT_ASSERT(a_full_status, !full_resp || (count_ff == CW'(DEPTH)), "full status with room left")
   `SRT_ASSERT_NEXT(a_last_idle, list_done, state_ff == S_IDLE, "list did not end after last entry")
endmodule
